// ----- rtl/vri_pkg.sv -----
// shared types and constants for the voltage regulator interlock step block
// no dependencies; used by the controller, the datapath, the top level, the checker and the testbench
package vri_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } vri_state_t;

  typedef enum logic [2:0] {
    MOP_DTW,
    MOP_GDIFF,
    MOP_GG,
    MOP_KG,
    MOP_GRATE,
    MOP_UV
  } mul_op_t;

  typedef enum logic {
    DIV_G,
    DIV_RATE
  } div_sel_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_G_DIRECT,
    WB_G_DIV,
    WB_NUM,
    WB_M2,
    WB_DEN,
    WB_RATE,
    WB_POS,
    WB_UV
  } wb_t;

  // register indexes on the configuration port
  localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd0;
  localparam logic [2:0] REG_RISE_SETTLE      = 3'd1;
  localparam logic [2:0] REG_FALL_SETTLE      = 3'd2;
  localparam logic [2:0] REG_LEVEL_ONE        = 3'd3;
  localparam logic [2:0] REG_LEVEL_TWO        = 3'd4;
  localparam logic [2:0] REG_LEVEL_THREE      = 3'd5;

  localparam logic [63:0] W_RAD      = 64'd2000000;
  localparam logic [63:0] UV_PER_V   = 64'd1000000;
  localparam logic [20:0] UV_MAX     = 21'd2000000;
  localparam logic [63:0] INT64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [40:0] ticks_per_second;
    logic [31:0] rise_settle_ticks;
    logic [31:0] fall_settle_ticks;
    logic [23:0] level_one_khz;
    logic [23:0] level_two_khz;
    logic [23:0] level_three_khz;
  } vri_cfg_t;

  typedef struct packed {
    logic     in_ready;
    logic     prep;
    logic     mul_go;
    mul_op_t  mul_op;
    logic     div_go;
    div_sel_t div_sel;
    wb_t      wb;
    logic     load_out;
  } vri_cmd_t;

  typedef struct packed {
    logic started;
    logic mul_done;
    logic div_done;
    logic g_direct;
    logic out_free;
  } vri_status_t;

endpackage

// ----- rtl/vri_in_if.sv -----
// input channel: time stamp and requested frequency with valid/ready
// no dependencies
interface vri_in_if;
  logic        valid;
  logic        ready;
  logic [62:0] now_tick;
  logic [23:0] request_khz;

  modport source(output valid, now_tick, request_khz, input ready);
  modport sink(input valid, now_tick, request_khz, output ready);
endinterface

// ----- rtl/vri_out_if.sv -----
// output channel: applied frequency and filtered voltage with valid/ready
// no dependencies
interface vri_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] applied_khz;
  logic [20:0] voltage_uv;

  modport source(output valid, applied_khz, voltage_uv, input ready);
  modport sink(input valid, applied_khz, voltage_uv, output ready);
endinterface

// ----- rtl/vri_mul.sv -----
// 64x64 unsigned multiplier, one 32x32 partial product per cycle
// no dependencies; used by the datapath
module vri_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);

  logic [63:0]  a_reg;
  logic [63:0]  b_reg;
  logic [1:0]   step;
  logic         busy;
  logic [31:0]  part_a;
  logic [31:0]  part_b;
  logic [63:0]  pp;
  logic [6:0]   shamt;

  assign part_a = step[0] ? a_reg[63:32] : a_reg[31:0];
  assign part_b = step[1] ? b_reg[63:32] : b_reg[31:0];
  assign pp     = part_a * part_b;
  assign shamt  = {({1'b0, step[0]} + {1'b0, step[1]}), 5'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_reg <= b;
      prod  <= '0;
    end else if (busy) begin
      prod <= prod + ({64'b0, pp} << shamt);
    end
  end

endmodule

// ----- rtl/vri_div.sv -----
// restoring divider, 128-bit dividend by 64-bit divisor, one bit per cycle
// no dependencies; used by the datapath; quotient saturates to int64 max
module vri_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] num,
  input  logic [63:0]  den,
  output logic [63:0]  quo,
  output logic         done
);

  logic [127:0] num_sh;
  logic [63:0]  den_reg;
  logic [63:0]  rem;
  logic [62:0]  q;
  logic         over;
  logic [6:0]   idx;
  logic         busy;
  logic [64:0]  rem_sh;
  logic         qbit;
  logic [64:0]  rem_sub;

  assign rem_sh  = {rem, num_sh[127]};
  assign qbit    = rem_sh >= {1'b0, den_reg};
  assign rem_sub = rem_sh - {1'b0, den_reg};
  assign quo     = over ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= 7'd127;
      end else if (busy) begin
        idx <= idx - 7'd1;
        if (idx == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh  <= num;
      den_reg <= den;
      rem     <= '0;
      q       <= '0;
      over    <= 1'b0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= qbit ? rem_sub[63:0] : rem_sh[63:0];
      q      <= {q[61:0], qbit};
      // quotient bits at or above bit 63 mean the result does not fit
      if (qbit && idx >= 7'd63) begin
        over <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/vri_ctrl.sv -----
// controller state machine: sequences interlock, step size, filter update
// depends on vri_pkg; drives the datapath through vri_cmd_t
module vri_ctrl
  import vri_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  vri_status_t status,
  output vri_cmd_t    cmd
);

  vri_state_t state, state_next;
  mul_op_t    mul_op, mul_op_next;
  div_sel_t   div_sel, div_sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      mul_op  <= MOP_DTW;
      div_sel <= DIV_G;
    end else begin
      state   <= state_next;
      mul_op  <= mul_op_next;
      div_sel <= div_sel_next;
    end
  end

  always_comb begin
    state_next   = state;
    mul_op_next  = mul_op;
    div_sel_next = div_sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next  = ST_MUL_GO;
        mul_op_next = status.started ? MOP_DTW : MOP_UV;
      end
      ST_MUL_GO: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_MUL_GO;
          unique case (mul_op)
            MOP_DTW: begin
              if (status.g_direct) begin
                mul_op_next = MOP_GDIFF;
              end else begin
                state_next   = ST_DIV_GO;
                div_sel_next = DIV_G;
              end
            end
            MOP_GDIFF: mul_op_next = MOP_GG;
            MOP_GG:    mul_op_next = MOP_KG;
            MOP_KG: begin
              state_next   = ST_DIV_GO;
              div_sel_next = DIV_RATE;
            end
            MOP_GRATE: mul_op_next = MOP_UV;
            MOP_UV:    state_next  = ST_OUT;
            default:   state_next  = ST_IDLE;
          endcase
        end
      end
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_next  = ST_MUL_GO;
          mul_op_next = (div_sel == DIV_G) ? MOP_GDIFF : MOP_GRATE;
        end
      end
      ST_OUT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mul_op   = mul_op;
    cmd.div_sel  = div_sel;
    cmd.wb       = WB_NONE;
    unique case (state)
      ST_IDLE:   cmd.in_ready = 1'b1;
      ST_PREP:   cmd.prep     = 1'b1;
      ST_MUL_GO: cmd.mul_go   = 1'b1;
      ST_MUL_WAIT: begin
        if (status.mul_done) begin
          unique case (mul_op)
            MOP_DTW:   cmd.wb = status.g_direct ? WB_G_DIRECT : WB_NONE;
            MOP_GDIFF: cmd.wb = WB_NUM;
            MOP_GG:    cmd.wb = WB_M2;
            MOP_KG:    cmd.wb = WB_DEN;
            MOP_GRATE: cmd.wb = WB_POS;
            MOP_UV:    cmd.wb = WB_UV;
            default:   cmd.wb = WB_NONE;
          endcase
        end
      end
      ST_DIV_GO: cmd.div_go = 1'b1;
      ST_DIV_WAIT: begin
        if (status.div_done) cmd.wb = (div_sel == DIV_G) ? WB_G_DIV : WB_RATE;
      end
      ST_OUT: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/vri_dp.sv -----
// datapath: interlock state, filter state, shared multiplier and divider
// depends on vri_pkg, vri_mul, vri_div; commanded by vri_ctrl
module vri_dp
  import vri_pkg::*;
#(
  parameter int FRACTION_BITS = 40
) (
  input  logic        clk,
  input  logic        rst,
  input  vri_cfg_t    cfg,
  input  vri_cmd_t    cmd,
  output vri_status_t status,
  input  logic        in_valid,
  input  logic [62:0] in_now_tick,
  input  logic [23:0] in_request_khz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_applied_khz,
  output logic [20:0] out_voltage_uv
);

  localparam int GCAP_LOG2 = (62 - FRACTION_BITS) / 2;
  localparam logic [63:0] ONE_Q = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] GCAP  = 64'd1 << (FRACTION_BITS + GCAP_LOG2);
  localparam logic [63:0] V08   = ((64'd8 << FRACTION_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] V09   = ((64'd9 << FRACTION_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] V10   = ((64'd10 << FRACTION_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] V11   = ((64'd11 << FRACTION_BITS) + 64'd5) / 64'd10;
  localparam logic [63:0] K12   = ((64'd12 << FRACTION_BITS) + 64'd5) / 64'd10;

  logic [62:0] cur_now;
  logic [23:0] cur_req;
  logic        started;
  logic [62:0] last_tick;
  logic [1:0]  drive_level;
  logic [1:0]  requested_level;
  logic [23:0] granted_khz;
  logic [62:0] freq_hold_until;
  logic [62:0] volt_hold_until;
  logic [63:0] pos;
  logic [63:0] rate;
  logic [63:0] g;
  logic [63:0] num;
  logic [63:0] m2;
  logic [63:0] den;
  logic [62:0] dt;
  logic [20:0] uv_val;
  logic        mul_neg;
  logic        out_full;

  logic [1:0]   lvl;
  logic [63:0]  rise_sum;
  logic [63:0]  fall_sum;
  logic [62:0]  freq_hold_next;
  logic [62:0]  volt_hold_next;
  logic [63:0]  u_volt;
  logic [63:0]  lvl_volt;
  logic [63:0]  op_a;
  logic [63:0]  op_b;
  logic [63:0]  mag_a;
  logic [63:0]  mag_b;
  logic [127:0] prod;
  logic         mul_done;
  logic [63:0]  mq;
  logic [127:0] div_num;
  logic [63:0]  div_den;
  logic [63:0]  quo;
  logic         div_done;
  logic [63:0]  num_mag;

  function automatic logic [63:0] level_volt(input logic [1:0] l);
    logic [63:0] v;
    case (l)
      2'd0:    v = V08;
      2'd1:    v = V09;
      2'd2:    v = V10;
      default: v = V11;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // level of the held request
  always_comb begin
    if (cur_req < cfg.level_one_khz)        lvl = 2'd0;
    else if (cur_req < cfg.level_two_khz)   lvl = 2'd1;
    else if (cur_req < cfg.level_three_khz) lvl = 2'd2;
    else                                    lvl = 2'd3;
  end

  assign rise_sum = {1'b0, cur_now} + {32'b0, cfg.rise_settle_ticks};
  assign fall_sum = {1'b0, cur_now} + {32'b0, cfg.fall_settle_ticks};

  always_comb begin
    freq_hold_next = freq_hold_until;
    volt_hold_next = volt_hold_until;
    if (lvl > requested_level) begin
      freq_hold_next = rise_sum[63] ? {63{1'b1}} : rise_sum[62:0];
    end else if (lvl < requested_level) begin
      volt_hold_next = fall_sum[63] ? {63{1'b1}} : fall_sum[62:0];
    end
  end

  assign u_volt   = level_volt(drive_level);
  assign lvl_volt = level_volt(lvl);

  always_comb begin
    case (cmd.mul_op)
      MOP_DTW: begin
        op_a = {1'b0, dt};
        op_b = W_RAD;
      end
      MOP_GDIFF: begin
        op_a = g;
        op_b = u_volt - pos;
      end
      MOP_GG: begin
        op_a = g;
        op_b = g;
      end
      MOP_KG: begin
        op_a = K12;
        op_b = g;
      end
      MOP_GRATE: begin
        op_a = g;
        op_b = rate;
      end
      default: begin
        op_a = pos;
        op_b = UV_PER_V;
      end
    endcase
  end

  assign mag_a = abs64(op_a);
  assign mag_b = abs64(op_b);

  vri_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mul_go),
    .a    (mag_a),
    .b    (mag_b),
    .prod (prod),
    .done (mul_done)
  );

  // product back to fixed point, truncated and saturated on the magnitude
  always_comb begin
    logic [63:0] r;
    r = prod[FRACTION_BITS +: 64];
    if ((|prod[127:64+FRACTION_BITS]) || r[63]) r = INT64_MAX;
    mq = mul_neg ? (64'd0 - r) : r;
  end

  assign num_mag = abs64(num);

  always_comb begin
    if (cmd.div_sel == DIV_G) begin
      div_num = prod << FRACTION_BITS;
      div_den = {23'b0, cfg.ticks_per_second};
    end else begin
      div_num = {64'b0, num_mag} << FRACTION_BITS;
      div_den = den;
    end
  end

  vri_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .quo  (quo),
    .done (div_done)
  );

  assign status.started  = started;
  assign status.mul_done = mul_done;
  assign status.div_done = div_done;
  assign status.g_direct = (dt == '0) || (cfg.ticks_per_second == '0) ||
                           (|prod[127 -: FRACTION_BITS]);
  assign status.out_free = !out_full || out_ready;

  always_ff @(posedge clk) begin
    if (in_valid && cmd.in_ready) begin
      cur_now <= in_now_tick;
      cur_req <= in_request_khz;
    end
    if (cmd.mul_go) mul_neg <= op_a[63] ^ op_b[63];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      last_tick       <= '0;
      drive_level     <= '0;
      requested_level <= '0;
      granted_khz     <= '0;
      freq_hold_until <= '0;
      volt_hold_until <= '0;
      pos             <= '0;
      rate            <= '0;
      g               <= '0;
      num             <= '0;
      m2              <= '0;
      den             <= '0;
      dt              <= '0;
      uv_val          <= '0;
    end else begin
      if (cmd.prep) begin
        last_tick <= cur_now;
        dt        <= (cur_now > last_tick) ? (cur_now - last_tick) : '0;
        if (!started) begin
          started         <= 1'b1;
          drive_level     <= lvl;
          requested_level <= lvl;
          granted_khz     <= cur_req;
          freq_hold_until <= '0;
          volt_hold_until <= '0;
          pos             <= lvl_volt;
          rate            <= '0;
        end else begin
          requested_level <= lvl;
          freq_hold_until <= freq_hold_next;
          volt_hold_until <= volt_hold_next;
          if (cur_now >= volt_hold_next) drive_level <= lvl;
          if (cur_now >= freq_hold_next) granted_khz <= cur_req;
        end
      end
      case (cmd.wb)
        WB_G_DIRECT: g    <= (dt == '0) ? '0 : GCAP;
        WB_G_DIV:    g    <= (quo > GCAP) ? GCAP : quo;
        WB_NUM:      num  <= rate + mq;
        WB_M2:       m2   <= mq;
        WB_DEN:      den  <= ONE_Q + m2 + mq;
        WB_RATE:     rate <= num[63] ? (64'd0 - quo) : quo;
        WB_POS:      pos  <= pos + mq;
        WB_UV: begin
          if (mq[63])                    uv_val <= '0;
          else if (mq > {43'b0, UV_MAX}) uv_val <= UV_MAX;
          else                           uv_val <= mq[20:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.load_out) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_applied_khz <= granted_khz;
      out_voltage_uv  <= uv_val;
    end
  end

  assign out_valid = out_full;

`ifndef SYNTHESIS
  a_load_sets_full: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_full) else $error("result register not marked full");

  a_voltage_range: assert property (@(posedge clk) disable iff (rst)
    out_full |-> out_voltage_uv <= UV_MAX) else $error("voltage above range");

  a_first_item_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.prep && !started) |=> started) else $error("first item did not start");

  a_den_positive: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_go && cmd.div_sel == DIV_RATE) |-> (!den[63] && den >= ONE_Q))
    else $error("filter denominator below one");
`endif

endmodule

// ----- rtl/voltage_regulator_interlock_step.sv -----
// top level: configuration registers, controller and datapath
// depends on vri_pkg, vri_in_if, vri_out_if, vri_ctrl, vri_dp
//
// One item is worked at a time. The first item after reset needs only the
// product that scales the voltage. A later item takes six 64x64 products on
// one shared multiplier (four 32x32 partial products each) and two 128-step
// divisions on one shared bit-serial divider; when the step size needs no
// division (no time elapsed, zero ticks per second or a step beyond its cap)
// only the filter division is left. A finished result waits in an output
// register while the next item is already being taken.
// Registers sit on a 64-bit APB port at byte address 8*index; configure
// only while the block is idle.
module voltage_regulator_interlock_step
  import vri_pkg::*;
#(
  parameter int FRACTION_BITS = 40
) (
  input  logic        clk,
  input  logic        rst,
  vri_in_if.sink      in_item,
  vri_out_if.source   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  vri_cfg_t    cfg;
  vri_cmd_t    cmd;
  vri_status_t status;
  logic        cfg_write;
  logic [2:0]  reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second  <= 41'd1000000000000;
      cfg.rise_settle_ticks <= 32'd2000000;
      cfg.fall_settle_ticks <= 32'd1000000;
      cfg.level_one_khz     <= 24'd400000;
      cfg.level_two_khz     <= 24'd800000;
      cfg.level_three_khz   <= 24'd1200000;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_TICKS_PER_SECOND: cfg.ticks_per_second  <= pwdata[40:0];
        REG_RISE_SETTLE:      cfg.rise_settle_ticks <= pwdata[31:0];
        REG_FALL_SETTLE:      cfg.fall_settle_ticks <= pwdata[31:0];
        REG_LEVEL_ONE:        cfg.level_one_khz     <= pwdata[23:0];
        REG_LEVEL_TWO:        cfg.level_two_khz     <= pwdata[23:0];
        REG_LEVEL_THREE:      cfg.level_three_khz   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TICKS_PER_SECOND: prdata = {23'b0, cfg.ticks_per_second};
      REG_RISE_SETTLE:      prdata = {32'b0, cfg.rise_settle_ticks};
      REG_FALL_SETTLE:      prdata = {32'b0, cfg.fall_settle_ticks};
      REG_LEVEL_ONE:        prdata = {40'b0, cfg.level_one_khz};
      REG_LEVEL_TWO:        prdata = {40'b0, cfg.level_two_khz};
      REG_LEVEL_THREE:      prdata = {40'b0, cfg.level_three_khz};
      default:              prdata = '0;
    endcase
  end

  assign in_item.ready = cmd.in_ready;

  vri_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_item.valid),
    .status  (status),
    .cmd     (cmd)
  );

  vri_dp #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .in_valid       (in_item.valid),
    .in_now_tick    (in_item.now_tick),
    .in_request_khz (in_item.request_khz),
    .out_valid      (out_item.valid),
    .out_ready      (out_item.ready),
    .out_applied_khz(out_item.applied_khz),
    .out_voltage_uv (out_item.voltage_uv)
  );

endmodule

// ----- verif/vri_checker.sv -----
`timescale 1ns / 100ps
// checker for the voltage regulator interlock step: watches both channels and the apb port,
// predicts each result in fixed point and compares; depends on vri_pkg, vri_in_if, vri_out_if
module vri_checker
  import vri_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vri_in_if           in_ch,
  vri_out_if          out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  localparam int FB = 40;
  localparam logic [63:0] GCAP = 64'd1 << (FB + (62 - FB) / 2);
  localparam logic [63:0] T63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [23:0] applied_khz;
    logic [20:0] voltage_uv;
  } regulator_out_t;

  regulator_out_t expected_q[$];
  vri_cfg_t cfg;

  logic        started;
  logic [63:0] last_tick, freq_hold_until, volt_hold_until;
  logic [1:0]  drive_level, requested_level;
  logic [23:0] granted_khz;
  logic [63:0] position, rate;

  function automatic logic [63:0] magnitude(logic [63:0] a);
    return a[63] ? -a : a;
  endfunction

  function automatic logic [63:0] apply_sign(logic [63:0] m, bit neg);
    if (m > INT64_MAX) m = INT64_MAX;
    return neg ? -m : m;
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic [63:0] r;
    p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
    if ((p >> (64 + FB)) != 0) r = INT64_MAX;
    else r = p[FB+63:FB];
    return apply_sign(r, a[63] != b[63]);
  endfunction

  function automatic logic [63:0] quotient_sat(logic [127:0] dvd, logic [63:0] d);
    logic [127:0] q;
    q = dvd / {64'd0, d};
    return (q >= (128'd1 << 63)) ? INT64_MAX : q[63:0];
  endfunction

  function automatic logic [63:0] fx_div(logic [63:0] num, logic [63:0] den);
    logic [127:0] dvd;
    dvd = {64'd0, magnitude(num)} << FB;
    return apply_sign(quotient_sat(dvd, den), num[63]);
  endfunction

  function automatic logic [63:0] tenths(logic [63:0] n);
    return ((n << FB) + 64'd5) / 64'd10;
  endfunction

  function automatic logic [63:0] step_gain(logic [63:0] dt);
    logic [127:0] p;
    logic [63:0] g;
    if (dt == 0) return 64'd0;
    if (cfg.ticks_per_second == 0) return GCAP;
    p = {64'd0, dt} * {64'd0, W_RAD};
    if ((p >> (128 - FB)) != 0) return GCAP;
    g = quotient_sat(p << FB, {23'd0, cfg.ticks_per_second});
    return g > GCAP ? GCAP : g;
  endfunction

  function automatic logic [1:0] level_for(logic [23:0] khz);
    if (khz < cfg.level_one_khz) return 2'd0;
    if (khz < cfg.level_two_khz) return 2'd1;
    if (khz < cfg.level_three_khz) return 2'd2;
    return 2'd3;
  endfunction

  function automatic logic [63:0] settle_end(logic [63:0] now, logic [31:0] settle);
    logic [63:0] s;
    s = now + {32'd0, settle};
    return s > T63_MAX ? T63_MAX : s;
  endfunction

  task automatic regulate(input logic [62:0] now_in, input logic [23:0] req);
    logic [63:0] now, dt, g, u, num, den, uv;
    logic [1:0] lvl;
    regulator_out_t r;
    now = {1'b0, now_in};
    lvl = level_for(req);
    if (!started) begin
      started = 1'b1;
      drive_level = lvl;
      requested_level = lvl;
      granted_khz = req;
      freq_hold_until = 0;
      volt_hold_until = 0;
      position = tenths(64'd8 + lvl);
      rate = 0;
    end else begin
      dt = now > last_tick ? now - last_tick : 64'd0;
      if (lvl > requested_level) freq_hold_until = settle_end(now, cfg.rise_settle_ticks);
      else if (lvl < requested_level) volt_hold_until = settle_end(now, cfg.fall_settle_ticks);
      requested_level = lvl;
      if (now >= volt_hold_until) drive_level = lvl;
      if (now >= freq_hold_until) granted_khz = req;
      g = step_gain(dt);
      u = tenths(64'd8 + drive_level);
      num = rate + fx_mul(g, u - position);
      den = (64'd1 << FB) + fx_mul(g, g) + fx_mul(tenths(64'd12), g);
      rate = fx_div(num, den);
      position = position + fx_mul(g, rate);
    end
    last_tick = now;
    uv = fx_mul(position, UV_PER_V);
    if (uv[63]) uv = 0;
    else if (uv > 64'd2000000) uv = 64'd2000000;
    r.applied_khz = granted_khz;
    r.voltage_uv = uv[20:0];
    expected_q = {expected_q, r};
  endtask

  task automatic report(input string msg);
    $display("checker: %s", msg);
    errors++;
  endtask

  always @(posedge clk) begin
    regulator_out_t e;
    if (rst) begin
      cfg.ticks_per_second = 41'd1000000000000;
      cfg.rise_settle_ticks = 32'd2000000;
      cfg.fall_settle_ticks = 32'd1000000;
      cfg.level_one_khz = 24'd400000;
      cfg.level_two_khz = 24'd800000;
      cfg.level_three_khz = 24'd1200000;
      started = 0;
      last_tick = 0;
      freq_hold_until = 0;
      volt_hold_until = 0;
      drive_level = 0;
      requested_level = 0;
      granted_khz = 0;
      position = 0;
      rate = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_TICKS_PER_SECOND: cfg.ticks_per_second = pwdata[40:0];
          REG_RISE_SETTLE:      cfg.rise_settle_ticks = pwdata[31:0];
          REG_FALL_SETTLE:      cfg.fall_settle_ticks = pwdata[31:0];
          REG_LEVEL_ONE:        cfg.level_one_khz = pwdata[23:0];
          REG_LEVEL_TWO:        cfg.level_two_khz = pwdata[23:0];
          REG_LEVEL_THREE:      cfg.level_three_khz = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (out_ch.applied_khz !== e.applied_khz)
            report($sformatf("applied_khz %0d, expected %0d", out_ch.applied_khz,
                             e.applied_khz));
          if (out_ch.voltage_uv !== e.voltage_uv)
            report($sformatf("voltage_uv %0d, expected %0d", out_ch.voltage_uv,
                             e.voltage_uv));
        end
      end
      if (in_ch.valid && in_ch.ready) regulate(in_ch.now_tick, in_ch.request_khz);
    end
    pending = expected_q.size();
  end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// top of the testbench: clock, reset, apb writes, input items and result stalls
// depends on vri_pkg, vri_in_if, vri_out_if, vri_checker and the block
module tb;
  import vri_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [62:0] TICK_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  int          errors, pending;
  bit          no_idle;
  logic [62:0] now;
  logic [23:0] thr [3];

  vri_in_if  in_item();
  vri_out_if out_item();

  voltage_regulator_interlock_step dut (
    .clk(clk), .rst(rst), .in_item(in_item), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vri_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_item), .out_ch(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx == REG_LEVEL_ONE) thr[0] = value[23:0];
    if (idx == REG_LEVEL_TWO) thr[1] = value[23:0];
    if (idx == REG_LEVEL_THREE) thr[2] = value[23:0];
    @(posedge clk);
  endtask

  task automatic send(input logic [62:0] t, input logic [23:0] khz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_item.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_item.valid <= 1;
    in_item.now_tick <= t;
    in_item.request_khz <= khz;
    do @(posedge clk); while (!in_item.ready);
  endtask

  // let the block drain before touching the registers
  task automatic drain();
    in_item.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [62:0] advance(logic [62:0] t);
    case ($urandom_range(0, 19))
      0: return t;
      1: return t - 63'($urandom_range(0, 5000));
      2: return t + 63'({$urandom, $urandom} >> $urandom_range(1, 40));
      3: return t + 63'($urandom_range(1, 200));
      default: return t + 63'($urandom_range(1, 3000000));
    endcase
  endfunction

  function automatic logic [23:0] pick_khz();
    logic [23:0] base;
    if ($urandom_range(0, 2) == 0) return 24'($urandom);
    base = thr[$urandom_range(0, 2)];
    return base + 24'($urandom_range(0, 4)) - 24'd2;
  endfunction

  function automatic logic [63:0] pick_settle();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF;
      2: return 64'($urandom_range(1, 1000));
      default: return 64'($urandom_range(100000, 5000000));
    endcase
  endfunction

  task automatic random_config(input int ph);
    logic [63:0] tps;
    case (ph % 5)
      0: tps = 64'd1;
      1: tps = 64'd1 << 40;
      2: tps = 64'h1FF_FFFF_FFFF;
      3: tps = 64'd0;
      default: tps = {$urandom, $urandom} & 64'h1FF_FFFF_FFFF;
    endcase
    reg_write(REG_TICKS_PER_SECOND, tps);
    reg_write(REG_RISE_SETTLE, pick_settle());
    reg_write(REG_FALL_SETTLE, pick_settle());
    if (ph == 2) begin
      reg_write(REG_LEVEL_ONE, 64'd0);
      reg_write(REG_LEVEL_TWO, 64'hFF_FFFF);
      reg_write(REG_LEVEL_THREE, 64'hFF_FFFF);
    end else begin
      reg_write(REG_LEVEL_ONE, 64'($urandom_range(0, 6000000)));
      reg_write(REG_LEVEL_TWO, 64'($urandom_range(4000000, 12000000)));
      reg_write(REG_LEVEL_THREE, 64'($urandom_range(8000000, 24'hFF_FFFF)));
    end
    reg_write(REG_UNUSED, {$urandom, $urandom});
  endtask

  // result side: random stall before each result transfer
  initial begin
    int stall;
    out_item.ready = 0;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_item.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_item.ready <= 1;
      do @(posedge clk); while (!out_item.valid);
    end
  end

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    in_item.valid = 0;
    in_item.now_tick = 0;
    in_item.request_khz = 0;
    no_idle = 0;
    thr[0] = 24'd400000;
    thr[1] = 24'd800000;
    thr[2] = 24'd1200000;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: first item, holds after rise and fall, thresholds, time quirks
    send(63'd1000, 24'd0);
    send(63'd1000, 24'd500000);
    send(63'd1500000, 24'd500000);
    send(63'd3100000, 24'd500000);
    send(63'd4000000, 24'd100);
    send(63'd4500000, 24'd399999);
    send(63'd6000000, 24'd400000);
    send(63'd6100000, 24'd799999);
    send(63'd6200000, 24'd800000);
    send(63'd6300000, 24'd1199999);
    send(63'd6400000, 24'd1200000);
    send(63'd9000000, 24'hFF_FFFF);
    send(63'd5000000, 24'd900000);
    send(63'd1005000000, 24'd300000);
    send(63'd11005000000, 24'd1300000);
    now = 63'd11005000000;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      random_config(ph);
      no_idle = (ph == 3);
      for (int i = 0; i < 110; i++) begin
        now = advance(now);
        send(now, pick_khz());
      end
      drain();
      no_idle = 0;
    end

    // reset tick rate and thresholds, longest settle times, then the far end of time with a pending rise
    reg_write(REG_TICKS_PER_SECOND, 64'd1000000000000);
    reg_write(REG_RISE_SETTLE, 64'hFFFF_FFFF);
    reg_write(REG_FALL_SETTLE, 64'hFFFF_FFFF);
    reg_write(REG_LEVEL_ONE, 64'd400000);
    reg_write(REG_LEVEL_TWO, 64'd800000);
    reg_write(REG_LEVEL_THREE, 64'd1200000);
    send(TICK_MAX - 63'd10, 24'd0);
    send(TICK_MAX - 63'd5, 24'hFF_FFFF);
    send(TICK_MAX, 24'd100);
    send(TICK_MAX, 24'hFF_FFFF);
    in_item.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- voltage_regulator_interlock_step.f -----
rtl/vri_pkg.sv
rtl/vri_in_if.sv
rtl/vri_out_if.sv
rtl/vri_mul.sv
rtl/vri_div.sv
rtl/vri_ctrl.sv
rtl/vri_dp.sv
rtl/voltage_regulator_interlock_step.sv
verif/vri_checker.sv
verif/tb.sv
